/* rtl/ppmd_pkg.sv */
// ----------------------------------------------------------------------------
// ppmd_pkg: shared types and constants for the position PID motor drive
// Field widths, register indexes, reset values and the structs that pass
// between the configuration file, the control law and the top level.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    localparam int POS_W       = 24;
    localparam int ERR_W       = POS_W + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 40;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int DEAD_W      = 8;
    localparam int CMD_W       = 16;
    localparam int MAG_W       = 16;
    localparam int FRAC_W      = 8;
    localparam int PROD_P_W    = GAIN_W + ERR_W;
    localparam int PROD_I_W    = GAIN_W + SUM_W;
    localparam int PROD_D_W    = GAIN_W + DIFF_W;
    localparam int ACC_W       = PROD_I_W + 2;
    localparam int SCALED_W    = ACC_W - FRAC_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CMD_W - 1 - MAG_W;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET     = 16'sd384;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RESET     = 16'sd768;
    localparam logic [LIMIT_W-1:0]       DRIVE_LIMIT_RESET = 15'd255;
    localparam logic [DEAD_W-1:0]        DEAD_ZONE_RESET   = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_FORWARD_LOCK = 3'd3,
        REG_REVERSE_LOCK = 3'd4,
        REG_DRIVE_LIMIT  = 3'd5,
        REG_DEAD_ZONE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic                     forward_lock;
        logic                     reverse_lock;
        logic [LIMIT_W-1:0]       drive_limit;
        logic [DEAD_W-1:0]        dead_zone;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  error;
        logic signed [SUM_W-1:0]  error_sum;
        logic signed [DIFF_W-1:0] error_diff;
        logic                     locked;
    } law_in_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] drive_cmd;
        logic                    direction;
        logic [MAG_W-1:0]        magnitude;
        logic                    locked;
    } law_out_t;

endpackage

/* rtl/ppmd_cfg.sv */
// ----------------------------------------------------------------------------
// ppmd_cfg: configuration register file
// Holds gains, direction locks, drive limit and dead-zone offset.
// ----------------------------------------------------------------------------
module ppmd_cfg
    import ppmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= GAIN_P_RESET;
            cfg_reg.gain_i       <= GAIN_I_RESET;
            cfg_reg.gain_d       <= GAIN_D_RESET;
            cfg_reg.forward_lock <= 1'b0;
            cfg_reg.reverse_lock <= 1'b0;
            cfg_reg.drive_limit  <= DRIVE_LIMIT_RESET;
            cfg_reg.dead_zone    <= DEAD_ZONE_RESET;
        end
        else if (cfg_valid)
        begin
            // drop writes to unknown indexes
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:       cfg_reg.gain_p       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:       cfg_reg.gain_i       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:       cfg_reg.gain_d       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_FORWARD_LOCK: cfg_reg.forward_lock <= cfg_data[0];
                REG_REVERSE_LOCK: cfg_reg.reverse_lock <= cfg_data[0];
                REG_DRIVE_LIMIT:  cfg_reg.drive_limit  <= cfg_data[LIMIT_W-1:0];
                REG_DEAD_ZONE:    cfg_reg.dead_zone    <= cfg_data[DEAD_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

/* rtl/ppmd_law.sv */
// ----------------------------------------------------------------------------
// ppmd_law: PID control law
// Weighted sum of the three terms, scale by 1/256 toward zero, clamp, and
// split into direction and PWM magnitude.
// ----------------------------------------------------------------------------
module ppmd_law
    import ppmd_pkg::*;
(
    input  cfg_t     cfg,
    input  law_in_t  law_in,
    output law_out_t law_out
);

    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    round_adj;
    logic signed [ACC_W-1:0]    acc_adj;
    logic signed [SCALED_W-1:0] cmd_full;
    logic signed [CMD_W-1:0]    limit_pos;
    logic signed [CMD_W-1:0]    limit_neg;
    logic signed [CMD_W-1:0]    cmd;
    logic [CMD_W-1:0]           cmd_abs;

    always_comb
    begin
        prod_p = cfg.gain_p * law_in.error;
        prod_i = cfg.gain_i * law_in.error_sum;
        prod_d = cfg.gain_d * law_in.error_diff;
        acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

        // bias negative sums so the shift truncates toward zero
        round_adj = acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0;
        acc_adj   = acc + round_adj;
        cmd_full  = $signed(acc_adj[ACC_W-1:FRAC_W]);

        limit_pos = $signed({1'b0, cfg.drive_limit});
        limit_neg = -limit_pos;

        if (law_in.locked)
            cmd = '0;
        else if (cmd_full > SCALED_W'(limit_pos))
            cmd = limit_pos;
        else if (cmd_full < SCALED_W'(limit_neg))
            cmd = limit_neg;
        else
            cmd = cmd_full[CMD_W-1:0];

        cmd_abs = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);

        law_out.drive_cmd = cmd;
        law_out.direction = cmd[CMD_W-1];
        law_out.magnitude = cmd_abs + MAG_W'(cfg.dead_zone);
        law_out.locked    = law_in.locked;
    end

endmodule

/* rtl/position_pid_motor_drive_top.sv */
// ----------------------------------------------------------------------------
// position_pid_motor_drive_top: one-channel positional PID motor drive
// Error, saturating integral and derivative, then the PID law and clamp.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one sample (measured and target encoder position).
//   m_tdata returns the clamped command, its direction bit and the PWM
//   compare value; m_tuser flags a sample that a direction lock zeroed.
//   cfg_* writes one register per transaction (index 0..6: gain_p, gain_i,
//   gain_d, forward_lock, reverse_lock, drive_limit, dead_zone); write only
//   while no transaction is in flight. cfg_ready is always high.
// Throughput: one transaction per cycle while m_tready is high. Three
//   registers in a row (input, state update, result) each hold one item;
//   the integral and previous error update as a sample leaves the input
//   register, so the next sample sees them at once.
// Stall: each stage has its own ready, so a held m_tready fills the three
//   stages and then drops s_tready; bubbles are squeezed out on the way.
// Reset: clears valids, the integral and the previous error, and loads
//   the register defaults (Kp 1.5, Ki 0, Kd 3.0, limit 255, no locks).
// ----------------------------------------------------------------------------
module position_pid_motor_drive_top
    import ppmd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // [23:0] measured_pos, [47:24] target_pos
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [15:0] drive_cmd, [16] direction, [32:17] magnitude, [39:33] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] locked
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    ppmd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage 1: captured sample
    logic                    s1_valid_reg;
    logic signed [POS_W-1:0] s1_meas_reg;
    logic signed [POS_W-1:0] s1_targ_reg;

    // Stage 2: error terms ready for the law
    logic    s2_valid_reg;
    law_in_t s2_reg;
    law_in_t s2_next;

    // Controller state
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0] prev_error_reg;

    // Result
    logic     out_valid_reg;
    law_out_t out_reg;
    law_out_t law_out;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic s1_move;

    logic signed [SUM_W:0] sum_wide;

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign s1_move   = s1_valid_reg && s2_ready;

    // Error, lock decision, saturating integral and derivative difference
    always_comb
    begin
        s2_next.error = ERR_W'(s1_meas_reg) - ERR_W'(s1_targ_reg);
        s2_next.locked = (cfg.forward_lock && (s2_next.error > 0)) ||
                         (cfg.reverse_lock && (s2_next.error < 0));
        sum_wide = (SUM_W + 1)'(error_sum_reg) + (SUM_W + 1)'(s2_next.error);
        // clip at the 40-bit rails when the extra sign bit disagrees
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            s2_next.error_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}};
        else
            s2_next.error_sum = sum_wide[SUM_W-1:0];
        s2_next.error_diff = DIFF_W'(s2_next.error) - DIFF_W'(prev_error_reg);
    end

    ppmd_law u_law
    (
        .cfg     (cfg),
        .law_in  (s2_reg),
        .law_out (law_out)
    );

    // Valids and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
            // hold the state when a lock zeroes the sample
            if (s1_move && !s2_next.locked)
            begin
                error_sum_reg  <= s2_next.error_sum;
                prev_error_reg <= s2_next.error;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s1_ready)
        begin
            s1_meas_reg <= $signed(s_tdata[POS_W-1:0]);
            s1_targ_reg <= $signed(s_tdata[2*POS_W-1:POS_W]);
        end
        if (s1_move)
            s2_reg <= s2_next;
        if (s2_valid_reg && out_ready)
            out_reg <= law_out;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.magnitude, out_reg.direction,
                       out_reg.drive_cmd};
    assign m_tuser  = out_reg.locked;

endmodule
